/* design/cfl_timestep_reduction_defines.svh */
// Assertion macros for the cfl_timestep_reduction checker.
// Included by the checker file only.
`ifndef CFL_TIMESTEP_REDUCTION_DEFINES_SVH
`define CFL_TIMESTEP_REDUCTION_DEFINES_SVH
// implication checked every clock outside reset
`define CFL_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication checked every clock outside reset
`define CFL_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

/* design/cfl_pkg.sv */
// Package for the CFL time-step block: widths, constants, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package cfl_pkg;
   localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
   localparam int unsigned DIV_STEPS = 64;

   typedef enum logic [1:0] {
      MODE_MAX  = 2'd0,
      MODE_SUM  = 2'd1,
      MODE_RSS  = 2'd2,
      MODE_RSS3 = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_GAMMA  = 3'd0,
      CSR_INV_DX = 3'd1,
      CSR_INV_DY = 3'd2,
      CSR_INV_DZ = 3'd3,
      CSR_MODE   = 3'd4,
      CSR_COEFF  = 3'd5
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_A2,
      ST_SQRT_A,
      ST_RATE_X,
      ST_RATE_Y,
      ST_RATE_Z,
      ST_COMBINE,
      ST_SHIFT_K,
      ST_SQ_SUM,
      ST_SQRT_R,
      ST_UPDATE,
      ST_DIV_DT,
      ST_OUT
   } state_type;

   // request to the shared divide / square-root unit
   typedef struct packed {
      logic        start_div;
      logic        start_sqrt;
      logic [63:0] num;
      logic [63:0] den;
   } iter_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } iter_rsp_type;
endpackage

/* design/cfl_iter.sv */
// Shared iterative unit: 64-bit restoring division (one quotient bit per
// cycle) and 64-bit integer square root (one result bit per cycle).
// Depends on cfl_pkg.
`timescale 1ns / 1ps
module cfl_iter (
   input  logic                 clock,
   input  logic                 reset,
   input  cfl_pkg::iter_req_type req,
   output cfl_pkg::iter_rsp_type rsp
);
   logic        busy_ff, busy_in;
   logic        is_sqrt_ff, is_sqrt_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] x_ff, x_in;       // dividend shift or sqrt remainder source
   logic [64:0] rem_ff, rem_in;
   logic [63:0] q_ff, q_in;
   logic [63:0] d_ff, d_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [65:0] strial;
   logic [65:0] srem;

   always_comb begin
      busy_in    = busy_ff;
      is_sqrt_in = is_sqrt_ff;
      cnt_in     = cnt_ff;
      x_in       = x_ff;
      rem_in     = rem_ff;
      q_in       = q_ff;
      d_in       = d_ff;
      done_in    = 1'b0;
      trial      = '0;
      srem       = '0;
      strial     = '0;
      if (!busy_ff) begin
         if (req.start_div || req.start_sqrt) begin
            busy_in    = 1'b1;
            is_sqrt_in = req.start_sqrt;
            x_in       = req.num;
            d_in       = req.den;
            rem_in     = '0;
            q_in       = '0;
            cnt_in     = req.start_sqrt ? 7'd32 : 7'(cfl_pkg::DIV_STEPS);
         end
      end else if (!is_sqrt_ff) begin
         // shift in one dividend bit, subtract if it fits
         trial = {rem_ff[63:0], x_ff[63]};
         x_in  = {x_ff[62:0], 1'b0};
         if (trial >= {1'b0, d_ff}) begin
            rem_in = trial - {1'b0, d_ff};
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         // bring down two radicand bits, try root*4+1
         srem   = {rem_ff[63:0], x_ff[63:62]};
         x_in   = {x_ff[61:0], 2'b00};
         strial = {q_ff[63:0], 2'b01};
         if (srem >= strial) begin
            rem_in = 65'(srem - strial);
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = srem[64:0];
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      is_sqrt_ff <= is_sqrt_in;
      cnt_ff     <= cnt_in;
      x_ff       <= x_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      d_ff       <= d_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = q_ff;
endmodule

/* design/cfl_timestep_reduction.sv */
// CFL time-step reduction: top level with sequencer, multiplier step and
// configuration registers. Depends on cfl_pkg and cfl_iter.
// Usage:
//   Input channel req_*: one grid cell per item (density, pressure, three
//   velocities, last_cell). req_stall is high while a cell is in progress
//   and during reset; the block takes one cell at a time.
//   Result channel rsp_*: one item (time_step, zero_speed_error) after a cell
//   with last_cell set; other cells give nothing.
//   Configuration: csr_write_enable, csr_index, csr_write_data; write only
//   while idle.
// Steps per cell: a 64-step division for gamma*p/rho, a 32-step square
// root and the three axis rates, in that order, in max or sum mode.
// Root-sum-square mode adds a shift search, one shift step at a time, and
// another 32-step root. A last cell adds the 64-step result division
// (skipped when the maximum rate is zero), and the result then waits
// while rsp_stall is high. The divisions and square roots run on one
// shared divide/square-root unit, which sets the rate.
// Reset clears the running maximum and loads register defaults. While
// rsp_stall is high the result holds and no new cell is taken.
`timescale 1ns / 1ps
module cfl_timestep_reduction (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_density,
   input  logic [31:0] req_pressure,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic        req_last_cell,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_time_step,
   output logic        rsp_zero_speed_error,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   cfl_pkg::state_type state_ff, state_in;
   cfl_pkg::iter_req_type ireq;
   cfl_pkg::iter_rsp_type irsp;

   logic [18:0] gamma_ff;
   logic [31:0] inv_dx_ff, inv_dy_ff, inv_dz_ff;
   logic [1:0]  mode_ff;
   logic [15:0] coeff_ff;

   logic [31:0] rho_ff, vx_ff, vy_ff, vz_ff;
   logic        last_ff;
   logic [47:0] a_ff;          // sound speed, 33 bits used
   logic [47:0] rx_ff, ry_ff, rz_ff;
   logic [47:0] rate_ff, rate_in;
   logic [47:0] max_ff;
   logic [5:0]  k_ff;
   logic [63:0] sq_ff;
   logic [1:0]  sq_cnt_ff;
   logic [31:0] dt_ff;
   logic        zse_ff;
   logic [47:0] rate_calc;
   logic [31:0] mag_sel, inv_sel;
   logic [33:0] s_sum;
   logic [65:0] prod_hi;
   logic [47:0] prod_lo;
   logic [66:0] rsum;
   logic [47:0] m3;
   logic [47:0] sh_sel;
   logic [30:0] sh_val;
   logic [63:0] sq_prod;
   logic [64:0] sq_acc;
   logic [63:0] a2_sat;
   logic [63:0] root_res;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (~v + 32'd1) : v;
   endfunction

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff  <= 19'd109227;
         inv_dx_ff <= 32'd65536;
         inv_dy_ff <= '0;
         inv_dz_ff <= '0;
         mode_ff   <= cfl_pkg::MODE_SUM;
         coeff_ff  <= 16'd26214;
      end else if (csr_write_enable) begin
         case (csr_index)
            cfl_pkg::CSR_GAMMA:  gamma_ff  <= csr_write_data[18:0];
            cfl_pkg::CSR_INV_DX: inv_dx_ff <= csr_write_data;
            cfl_pkg::CSR_INV_DY: inv_dy_ff <= csr_write_data;
            cfl_pkg::CSR_INV_DZ: inv_dz_ff <= csr_write_data;
            cfl_pkg::CSR_MODE:   mode_ff   <= csr_write_data[1:0];
            cfl_pkg::CSR_COEFF:  coeff_ff  <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // one axis rate per cycle through a shared 34x32 product
   always_comb begin
      case (state_ff)
         cfl_pkg::ST_RATE_Y: begin mag_sel = mag32(vy_ff); inv_sel = inv_dy_ff; end
         cfl_pkg::ST_RATE_Z: begin mag_sel = mag32(vz_ff); inv_sel = inv_dz_ff; end
         default:            begin mag_sel = mag32(vx_ff); inv_sel = inv_dx_ff; end
      endcase
      s_sum   = {2'b00, mag_sel} + a_ff[33:0];
      prod_hi = 66'(s_sum[33:16]) * 66'(inv_sel);
      prod_lo = 48'((64'(s_sum[15:0]) * 64'(inv_sel)) >> 16);
      if ((prod_hi + 66'(prod_lo)) > 66'(cfl_pkg::SAT48)) rate_calc = cfl_pkg::SAT48;
      else rate_calc = 48'(prod_hi + 66'(prod_lo));
   end

   assign m3 = (rx_ff >= ry_ff) ? ((rx_ff >= rz_ff) ? rx_ff : rz_ff)
                                : ((ry_ff >= rz_ff) ? ry_ff : rz_ff);
   assign rsum = 67'(rx_ff) + 67'(ry_ff) + 67'(rz_ff);

   always_comb begin
      case (sq_cnt_ff)
         2'd1:    sh_sel = ry_ff;
         2'd2:    sh_sel = rz_ff;
         default: sh_sel = rx_ff;
      endcase
      sh_val  = 31'(sh_sel >> k_ff);
      sq_prod = 64'(sh_val) * 64'(sh_val);
      sq_acc  = 65'(sq_ff) + 65'(sq_prod);
   end

   assign a2_sat = (rho_ff == 32'd0 || irsp.result > 64'(cfl_pkg::SAT48))
                   ? 64'(cfl_pkg::SAT48) : irsp.result;
   assign root_res = irsp.result;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cfl_pkg::ST_IDLE:    if (req_valid) state_in = cfl_pkg::ST_DIV_A2;
         cfl_pkg::ST_DIV_A2:  if (irsp.done) state_in = cfl_pkg::ST_SQRT_A;
         cfl_pkg::ST_SQRT_A:  if (irsp.done) state_in = cfl_pkg::ST_RATE_X;
         cfl_pkg::ST_RATE_X:  state_in = cfl_pkg::ST_RATE_Y;
         cfl_pkg::ST_RATE_Y:  state_in = cfl_pkg::ST_RATE_Z;
         cfl_pkg::ST_RATE_Z:  state_in = cfl_pkg::ST_COMBINE;
         cfl_pkg::ST_COMBINE:
            if (mode_ff == cfl_pkg::MODE_MAX || mode_ff == cfl_pkg::MODE_SUM)
               state_in = cfl_pkg::ST_UPDATE;
            else state_in = cfl_pkg::ST_SHIFT_K;
         cfl_pkg::ST_SHIFT_K: if ((m3 >> k_ff) < 48'h8000_0000) state_in = cfl_pkg::ST_SQ_SUM;
         cfl_pkg::ST_SQ_SUM:  if (sq_cnt_ff == 2'd2) state_in = cfl_pkg::ST_SQRT_R;
         cfl_pkg::ST_SQRT_R:  if (irsp.done) state_in = cfl_pkg::ST_UPDATE;
         cfl_pkg::ST_UPDATE:  state_in = last_ff ? cfl_pkg::ST_DIV_DT : cfl_pkg::ST_IDLE;
         cfl_pkg::ST_DIV_DT:
            if (max_ff == '0 || irsp.done) state_in = cfl_pkg::ST_OUT;
         cfl_pkg::ST_OUT:     if (!rsp_stall) state_in = cfl_pkg::ST_IDLE;
         default:             state_in = cfl_pkg::ST_IDLE;
      endcase
   end

   // unit requests: issued on entry to each iterative state
   always_comb begin
      ireq = '0;
      case (state_ff)
         cfl_pkg::ST_IDLE: begin
            ireq.start_div = req_valid;
            ireq.num = 64'(req_pressure) * 64'(gamma_ff);
            ireq.den = (req_density == 32'd0) ? 64'd1 : 64'(req_density);
         end
         cfl_pkg::ST_DIV_A2: begin
            ireq.start_sqrt = irsp.done;
            ireq.num = {a2_sat[47:0], 16'h0000};
         end
         cfl_pkg::ST_SQ_SUM: begin
            ireq.start_sqrt = (sq_cnt_ff == 2'd2);
            ireq.num = sq_acc[63:0];
         end
         cfl_pkg::ST_UPDATE: begin
            ireq.start_div = last_ff && (rate_ff > max_ff ? rate_ff : max_ff) != '0;
            ireq.num = {32'h0, coeff_ff, 16'h0000};
            ireq.den = 64'(rate_ff > max_ff ? rate_ff : max_ff);
         end
         default: ireq = '0;
      endcase
   end

   always_comb begin
      rate_in = rate_ff;
      if (state_ff == cfl_pkg::ST_COMBINE) begin
         if (mode_ff == cfl_pkg::MODE_MAX) rate_in = m3;
         else if (rsum > 67'(cfl_pkg::SAT48)) rate_in = cfl_pkg::SAT48;
         else rate_in = 48'(rsum);
      end else if (state_ff == cfl_pkg::ST_SQRT_R && irsp.done) begin
         if (root_res > (64'(cfl_pkg::SAT48) >> k_ff)) rate_in = cfl_pkg::SAT48;
         else rate_in = 48'(root_res << k_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfl_pkg::ST_IDLE;
         max_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == cfl_pkg::ST_UPDATE && !last_ff && rate_ff > max_ff)
            max_ff <= rate_ff;
         else if (state_ff == cfl_pkg::ST_UPDATE && last_ff && rate_ff > max_ff)
            max_ff <= rate_ff;
         else if (state_ff == cfl_pkg::ST_OUT && !rsp_stall)
            max_ff <= '0;
      end
      rate_ff <= rate_in;
      if (state_ff == cfl_pkg::ST_IDLE && req_valid) begin
         rho_ff  <= req_density;
         vx_ff   <= req_vel_x;
         vy_ff   <= req_vel_y;
         vz_ff   <= req_vel_z;
         last_ff <= req_last_cell;
      end
      if (state_ff == cfl_pkg::ST_SQRT_A && irsp.done) a_ff <= 48'(irsp.result[32:0]);
      if (state_ff == cfl_pkg::ST_RATE_X) rx_ff <= rate_calc;
      if (state_ff == cfl_pkg::ST_RATE_Y) ry_ff <= rate_calc;
      if (state_ff == cfl_pkg::ST_RATE_Z) rz_ff <= rate_calc;
      if (state_ff == cfl_pkg::ST_COMBINE) begin
         k_ff      <= '0;
         sq_ff     <= '0;
         sq_cnt_ff <= '0;
      end
      if (state_ff == cfl_pkg::ST_SHIFT_K && (m3 >> k_ff) >= 48'h8000_0000)
         k_ff <= k_ff + 6'd1;
      if (state_ff == cfl_pkg::ST_SQ_SUM) begin
         sq_ff     <= sq_acc[63:0];
         sq_cnt_ff <= sq_cnt_ff + 2'd1;
      end
      if (state_ff == cfl_pkg::ST_DIV_DT) begin
         if (max_ff == '0) begin
            dt_ff  <= '0;
            zse_ff <= 1'b1;
         end else begin
            dt_ff  <= irsp.result[31:0];
            zse_ff <= 1'b0;
         end
      end
   end

   cfl_iter u_iter (
      .clock (clock),
      .reset (reset),
      .req   (ireq),
      .rsp   (irsp)
   );

   assign req_stall            = reset || (state_ff != cfl_pkg::ST_IDLE);
   assign rsp_valid            = (state_ff == cfl_pkg::ST_OUT);
   assign rsp_time_step        = dt_ff;
   assign rsp_zero_speed_error = zse_ff;
endmodule

/* design/cfl_checker.sv */
// Port-level checker for cfl_timestep_reduction, bound to the top level.
// Depends on cfl_timestep_reduction_defines.svh.
`timescale 1ns / 1ps
`include "cfl_timestep_reduction_defines.svh"
module cfl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_time_step,
   input logic        rsp_zero_speed_error
);
   // result held while stalled
   `CFL_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_time_step), "result changed under stall")
   // a zero-speed result carries a zero step
   `CFL_ASSERT_IMP(a_zse_zero, rsp_valid && rsp_zero_speed_error, rsp_time_step == 32'd0, "zero-speed error with nonzero step")
   // no new cell while a result is pending
   `CFL_ASSERT_IMP(a_busy_out, rsp_valid, req_stall, "input open while result pending")
   // an accepted cell blocks the input next cycle
   `CFL_ASSERT_NXT(a_take, req_valid && !req_stall, req_stall && !rsp_valid, "cell accept not followed by busy")
endmodule

bind cfl_timestep_reduction cfl_checker u_cfl_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_time_step        (rsp_time_step),
   .rsp_zero_speed_error (rsp_zero_speed_error)
);

/* tb/tb_cfl_timestep_reduction.sv */
// Testbench for cfl_timestep_reduction: directed cells, then random grids over many
// register settings; results checked against an in-bench predictor or fixed values.
// Depends on cfl_pkg and the cfl_timestep_reduction RTL.
`timescale 1ns / 1ps
module tb_cfl_timestep_reduction;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = 400;
   localparam int PHASE_COUNT = 12;
   localparam int CELLS_PER_PHASE = 62;
   localparam logic [63:0] RATE_SAT = 64'h0000_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [31:0] density;
      logic [31:0] pressure;
      logic [31:0] vel_x;
      logic [31:0] vel_y;
      logic [31:0] vel_z;
      logic        last_cell;
      logic        fixed;
      logic [31:0] fixed_step;
      logic        fixed_zse;
   } cell_row_type;

   typedef struct packed {
      logic [31:0] time_step;
      logic        zero_speed_error;
   } step_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_density;
   logic [31:0] req_pressure;
   logic signed [31:0] req_vel_x;
   logic signed [31:0] req_vel_y;
   logic signed [31:0] req_vel_z;
   logic        req_last_cell;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_time_step;
   logic        rsp_zero_speed_error;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [31:0] csr_write_data;

   // predictor copy of the registers and the running peak rate
   logic [18:0] cfg_gamma;
   logic [31:0] cfg_inv_dx, cfg_inv_dy, cfg_inv_dz;
   cfl_pkg::mode_type cfg_mode;
   logic [15:0] cfg_courant;
   logic [63:0] peak_rate;

   step_result_type pending_steps[$];
   cell_row_type    directed_rows[0:11];
   int           error_count = 0;
   int           cells_sent = 0;
   int           steps_checked = 0;
   int           hold_left = 0;
   int           cycle_count = 0;

   cfl_timestep_reduction DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_steps.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic report(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] axis_rate(input logic [31:0] vel, input logic [63:0] speed,
                                             input logic [31:0] inv);
      logic [63:0] mag, s, r;
      mag = vel[31] ? {32'b0, (~vel) + 32'd1} : {32'b0, vel};
      s = mag + speed;
      r = (s >> 16) * inv + (((s & 64'hFFFF) * inv) >> 16);
      return (r > RATE_SAT) ? RATE_SAT : r;
   endfunction

   // advance the peak rate by one cell; return 1 with the time step on a last cell
   function automatic bit predict_step(input cell_row_type c, output step_result_type res);
      logic [63:0] a2, speed, rx, ry, rz, rate, m, dt;
      int k;
      a2 = (c.density != 0) ? ({45'b0, cfg_gamma} * c.pressure) / c.density : RATE_SAT;
      if (a2 > RATE_SAT) a2 = RATE_SAT;
      speed = int_sqrt(a2 << 16);
      rx = axis_rate(c.vel_x, speed, cfg_inv_dx);
      ry = axis_rate(c.vel_y, speed, cfg_inv_dy);
      rz = axis_rate(c.vel_z, speed, cfg_inv_dz);
      case (cfg_mode)
         cfl_pkg::MODE_MAX: begin
            rate = rx;
            if (ry > rate) rate = ry;
            if (rz > rate) rate = rz;
         end
         cfl_pkg::MODE_SUM: begin
            rate = rx + ry + rz;
            if (rate > RATE_SAT) rate = RATE_SAT;
         end
         default: begin
            m = rx;
            if (ry > m) m = ry;
            if (rz > m) m = rz;
            k = 0;
            while ((m >> k) >= (64'h1 << 31)) k++;
            rate = int_sqrt((rx >> k) * (rx >> k) + (ry >> k) * (ry >> k)
                            + (rz >> k) * (rz >> k));
            rate = (rate > (RATE_SAT >> k)) ? RATE_SAT : (rate << k);
         end
      endcase
      if (rate > peak_rate) peak_rate = rate;
      res = '0;
      if (!c.last_cell) return 0;
      if (peak_rate == 0) begin
         res.zero_speed_error = 1'b1;
      end else begin
         dt = ({48'b0, cfg_courant} << 16) / peak_rate;
         res.time_step = (dt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dt[31:0];
      end
      peak_rate = 0;
      return 1;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // offer one cell; hold valid across back-to-back items
   task automatic send_cell(input cell_row_type c, input bit busy_run);
      int gap;
      step_result_type res;
      gap = busy_run ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_density <= c.density;
      req_pressure <= c.pressure;
      req_vel_x <= c.vel_x;
      req_vel_y <= c.vel_y;
      req_vel_z <= c.vel_z;
      req_last_cell <= c.last_cell;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cells_sent++;
      if (predict_step(c, res)) begin
         if (c.fixed) res = '{time_step: c.fixed_step, zero_speed_error: c.fixed_zse};
         pending_steps.push_back(res);
      end
   endtask

   task automatic write_csr(input cfl_pkg::csr_idx_type idx, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         cfl_pkg::CSR_GAMMA:  cfg_gamma = value[18:0];
         cfl_pkg::CSR_INV_DX: cfg_inv_dx = value;
         cfl_pkg::CSR_INV_DY: cfg_inv_dy = value;
         cfl_pkg::CSR_INV_DZ: cfg_inv_dz = value;
         cfl_pkg::CSR_MODE:   cfg_mode = cfl_pkg::mode_type'(value[1:0]);
         cfl_pkg::CSR_COEFF:  cfg_courant = value[15:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      // a cell without a result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_inv(input int phase);
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return (phase == 1) ? 32'hFFFF_FFFF : $urandom;
         2: return $urandom;
         3: return 32'hFFFF_FFFF;
         default: return $urandom_range(1 << 12, 1 << 20);
      endcase
   endfunction

   function automatic cell_row_type random_cell();
      cell_row_type c;
      c = '0;
      c.density = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 1 << 20);
      c.pressure = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
      c.vel_x = $urandom;
      c.vel_y = $urandom;
      c.vel_z = $urandom;
      if ($urandom_range(0, 3) == 0) c.vel_x = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      if ($urandom_range(0, 24) == 0) begin
         // a still cell: zero pressure and zero flow
         c.pressure = 0;
         c.vel_x = 0;
         c.vel_y = 0;
         c.vel_z = 0;
      end
      c.last_cell = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 1) == 0) c.density = c.density | 32'h1;
      return c;
   endfunction

   // receiver: short and long stalls, free runs, and a long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         int run;
         int roll;
         bit level;
         roll = $urandom_range(0, 99);
         level = (roll >= 65);
         run = (roll < 65) ? $urandom_range(1, 25) :
               (roll < 95) ? $urandom_range(1, 4) : $urandom_range(20, 120);
         repeat (run) begin
            if (hold_left > 0) begin
               hold_left--;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= level;
            end
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_steps.size() == 0) begin
            report($sformatf("unexpected result time_step=%h zse=%b", rsp_time_step,
                             rsp_zero_speed_error));
         end else begin
            if (rsp_time_step !== pending_steps[0].time_step)
               report($sformatf("time_step %h, want %h", rsp_time_step,
                                pending_steps[0].time_step));
            if (rsp_zero_speed_error !== pending_steps[0].zero_speed_error)
               report($sformatf("zero_speed_error %b, want %b", rsp_zero_speed_error,
                                pending_steps[0].zero_speed_error));
            void'(pending_steps.pop_front());
            steps_checked++;
         end
      end
   end

   initial begin
      bit busy_run;
      reset = 1'b1;
      req_valid = 1'b0;
      req_density = '0;
      req_pressure = '0;
      req_vel_x = '0;
      req_vel_y = '0;
      req_vel_z = '0;
      req_last_cell = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = cfl_pkg::CSR_GAMMA;
      csr_write_data = '0;
      cfg_gamma = 19'd109227;
      cfg_inv_dx = 32'd65536;
      cfg_inv_dy = 32'd0;
      cfg_inv_dz = 32'd0;
      cfg_mode = cfl_pkg::MODE_SUM;
      cfg_courant = 16'd26214;
      peak_rate = 0;
      directed_rows = '{
         // still cell right after reset: zero speed
         '{32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1, 32'd0, 1'b1},
         '{32'd65536, 32'd65536, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
         '{32'd65536, 32'd65536, 32'd65536, 32'd0, 32'd0, 1'b1, 1'b0, 32'd0, 1'b0},
         '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
         // zero density saturates the squared sound speed
         '{32'd0, 32'd12345, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 32'd0, 1'b0},
         '{32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0,
           1'b0, 32'd0, 1'b0},
         '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1,
           1'b0, 32'd0, 1'b0},
         '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0, 1'b0},
         '{32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 32'd0, 1'b0},
         '{32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
           1'b1, 1'b0, 32'd0, 1'b0},
         '{32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1, 32'd0, 1'b1},
         '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 32'd0, 1'b0}
      };
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_cell(directed_rows[i], 1'b0);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         write_csr(cfl_pkg::CSR_GAMMA, (phase == 0) ? 32'd65536 :
                                       (phase == 1) ? 32'd262144 :
                                       $urandom_range(65536, 262144));
         write_csr(cfl_pkg::CSR_INV_DX, pick_inv(phase));
         write_csr(cfl_pkg::CSR_INV_DY, pick_inv(phase));
         write_csr(cfl_pkg::CSR_INV_DZ, pick_inv(phase));
         write_csr(cfl_pkg::CSR_MODE, (phase < 4) ? phase :
                   $urandom_range(cfl_pkg::MODE_MAX, cfl_pkg::MODE_RSS3));
         write_csr(cfl_pkg::CSR_COEFF, (phase == 3) ? 32'd0 : (phase == 1) ? 32'd65535 :
                                       $urandom_range(0, 65535));
         // hold off the receiver while cells keep coming
         if (phase == 2) hold_left = 3000;
         busy_run = (phase % 4 == 1);
         for (int n = 0; n < CELLS_PER_PHASE; n++) send_cell(random_cell(), busy_run);
      end

      req_valid <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d cells over %0d register settings, %0d time steps checked",
               cells_sent, PHASE_COUNT + 1, steps_checked);
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+design
design/cfl_pkg.sv
design/cfl_iter.sv
design/cfl_timestep_reduction.sv
design/cfl_checker.sv
tb/tb_cfl_timestep_reduction.sv
